### rtl/core/selective_repeat_send_window_macros.svh
// Assertion macros for the selective-repeat send window.
// Used by the top level; expects signals clk and arst_n in the calling scope.
`ifndef SELECTIVE_REPEAT_SEND_WINDOW_MACROS_SVH
`define SELECTIVE_REPEAT_SEND_WINDOW_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define SRSW_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SRSW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/srsw_pkg.sv
// Shared types, constants and helper functions of the selective-repeat send window.
// No dependencies; srsw_if, the top level and srsw_result_buf use it by scoped names.
`timescale 1ns / 1ps

package srsw_pkg;

	// Window geometry. WINDOW_SLOTS is a power of two that divides 2**SEQ_BITS.
	localparam int WINDOW_SLOTS = 32;
	localparam int SEQ_BITS     = 8;
	localparam int SLOT_W       = $clog2(WINDOW_SLOTS);
	localparam int CNT_W        = $clog2(WINDOW_SLOTS + 1);
	localparam int SUM_W        = SEQ_BITS + 1;
	localparam int TIMER_W      = 16;
	localparam int PEER_W       = 5;
	localparam int ADV_W        = 5;
	localparam int REQ_W        = 2;
	localparam int ACTION_W     = 3;

	localparam logic [SEQ_BITS-1:0] SEQ_MASK      = {SEQ_BITS{1'b1}};
	localparam logic [TIMER_W-1:0]  TIMEOUT_RESET = TIMER_W'(5000);
	localparam logic [PEER_W-1:0]   PEER_RESET    = {PEER_W{1'b1}};
	localparam logic [ADV_W-1:0]    ADV_MAX       = {ADV_W{1'b1}};

	// Request kinds.
	typedef enum logic [REQ_W-1:0] {
		REQ_SEND = 2'd0,
		REQ_ACK  = 2'd1,
		REQ_NACK = 2'd2,
		REQ_TICK = 2'd3
	} req_kind_t;

	// Result actions.
	typedef enum logic [ACTION_W-1:0] {
		ACT_NONE    = 3'd0,
		ACT_SEND    = 3'd1,
		ACT_RESEND  = 3'd2,
		ACT_ACK     = 3'd3,
		ACT_INVALID = 3'd4
	} action_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_FIN
	} state_t;

	// One result without its end-of-request mark.
	typedef struct packed {
		action_t               action;
		logic [SLOT_W-1:0]     slot;
		logic [SEQ_BITS-1:0]   seqnum;
		logic [ADV_W-1:0]      adv;
		logic                  empty;
	} result_t;

	// Controller to result buffer.
	typedef struct packed {
		logic push;
		logic finish;
	} buf_ctrl_t;

	// Result buffer to controller.
	typedef struct packed {
		logic ready;
		logic hold_busy;
	} buf_stat_t;

	// Free slots minus one, saturated to the header field.
	function automatic logic [ADV_W-1:0] adv_of(input logic [CNT_W-1:0] free);
		logic [CNT_W-1:0] dec;
		dec = free - 1'b1;
		if (free == '0) begin
			return '0;
		end else if (dec > CNT_W'(ADV_MAX)) begin
			return ADV_MAX;
		end else begin
			return ADV_W'(dec);
		end
	endfunction

endpackage

### rtl/core/srsw_if.sv
// Valid/ready channel interfaces of the selective-repeat send window.
// Depends on srsw_pkg for the field widths.
`timescale 1ns / 1ps

// Incoming requests: send, ack, nack or timer tick.
interface srsw_req_if;
	logic                          valid;
	logic                          ready;
	logic [srsw_pkg::REQ_W-1:0]    req_type;
	logic [srsw_pkg::SEQ_BITS-1:0] seqnum;
	logic [srsw_pkg::PEER_W-1:0]   peer_window;

	modport source (output valid, req_type, seqnum, peer_window, input ready);
	modport sink (input valid, req_type, seqnum, peer_window, output ready);
endinterface

// Outgoing results.
interface srsw_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [srsw_pkg::ACTION_W-1:0] action;
	logic [srsw_pkg::SLOT_W-1:0]   slot;
	logic [srsw_pkg::SEQ_BITS-1:0] out_seqnum;
	logic [srsw_pkg::ADV_W-1:0]    advertised_window;
	logic                          window_empty;
	logic                          last;

	modport source (output valid, action, slot, out_seqnum, advertised_window, window_empty,
		last, input ready);
	modport sink (input valid, action, slot, out_seqnum, advertised_window, window_empty,
		last, output ready);
endinterface

// Timeout register write channel.
interface srsw_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [srsw_pkg::TIMER_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### rtl/core/selective_repeat_send_window.sv
// Top level of the selective-repeat send window: controller, slot state and timer memory.
// Depends on srsw_pkg, srsw_if, srsw_ram, srsw_result_buf and the assertion macro header.
//
// Usage:
//   req carries one request per handshake: send new data, ack, nack or timer tick.
//   rsp returns the results of each request in order; the last one has last set.
//   cfg writes timeout_ticks; write it only while no request is in flight.
// Request flow:
//   A request is taken in ST_IDLE and handled in ST_EXEC; send, ack and nack give
//   one result through the output register, and a stalled rsp holds them in ST_EXEC.
//   A tick reads one slot timer per cycle from the timer memory while rsp is not
//   stalled, scanning the outstanding slots upward from the window base.
//   A new request is accepted only after the previous one is done, but while its
//   final result still waits in the output register.
// Reset:
//   All slots free, sequence numbers 0, peer window 31, timeout 5000 ticks.
//   Pending flags clear at once; timer entries are written before they are read.
// Stalls:
//   While rsp is stalled the tick scan holds its current slot and resumes when
//   the result can move on; no result is dropped or repeated.
`timescale 1ns / 1ps

`include "selective_repeat_send_window_macros.svh"

module selective_repeat_send_window (
	input  logic       clk,
	input  logic       arst_n,
	srsw_req_if.sink   req,
	srsw_rsp_if.source rsp,
	srsw_cfg_if.sink   cfg
);

	srsw_pkg::state_t                    state_q;
	srsw_pkg::state_t                    state_d;
	srsw_pkg::req_kind_t                 req_kind_q;
	logic [srsw_pkg::SEQ_BITS-1:0]       req_seq_q;
	logic [srsw_pkg::PEER_W-1:0]         req_peer_q;
	logic [srsw_pkg::TIMER_W-1:0]        timeout_q;
	logic [srsw_pkg::SEQ_BITS-1:0]       base_seq_q;
	logic [srsw_pkg::SEQ_BITS-1:0]       next_seq_q;
	logic [srsw_pkg::CNT_W-1:0]          free_q;
	logic [srsw_pkg::PEER_W-1:0]         peer_q;
	logic [srsw_pkg::WINDOW_SLOTS-1:0]   pending_q;
	logic [srsw_pkg::CNT_W-1:0]          cnt_q;
	logic [srsw_pkg::CNT_W-1:0]          span_q;
	logic                                any_q;
	logic                                scan_vld_s1;
	logic [srsw_pkg::SLOT_W-1:0]         scan_slot_s1;
	logic [srsw_pkg::SEQ_BITS-1:0]       scan_seq_s1;

	logic [srsw_pkg::SEQ_BITS-1:0]       outs;
	logic [srsw_pkg::ADV_W-1:0]          adv_now;
	logic [srsw_pkg::TIMER_W-1:0]        reload;
	logic [srsw_pkg::SLOT_W-1:0]         send_slot;
	logic                                send_ok;
	logic [srsw_pkg::SEQ_BITS-1:0]       next_inc;
	logic [srsw_pkg::SEQ_BITS-1:0]       seq_dist;
	logic                                ack_ok;
	logic                                nack_ok;
	logic [srsw_pkg::CNT_W-1:0]          ack_free;
	logic [srsw_pkg::WINDOW_SLOTS-1:0]   ack_mask;
	logic [srsw_pkg::CNT_W-1:0]          span_now;
	logic                                scan_more;
	logic [srsw_pkg::SLOT_W-1:0]         scan_addr;
	logic                                scan_pend;
	logic [srsw_pkg::TIMER_W-1:0]        tmr_rd;
	logic [srsw_pkg::TIMER_W-1:0]        tmr_dec;
	logic                                expire;
	logic                                scan_stall;
	logic                                scan_adv;
	logic                                exec_fire;
	logic                                req_ready;

	logic                                ram_we;
	logic [srsw_pkg::SLOT_W-1:0]         ram_waddr;
	logic [srsw_pkg::TIMER_W-1:0]        ram_wdata;
	logic                                ram_re;

	srsw_pkg::buf_ctrl_t                 buf_ctrl;
	srsw_pkg::buf_stat_t                 buf_stat;
	srsw_pkg::result_t                   res;

	// Window bookkeeping shared by all request kinds.
	assign outs      = next_seq_q - base_seq_q;
	assign adv_now   = srsw_pkg::adv_of(free_q);
	assign reload    = (timeout_q == '0) ? srsw_pkg::TIMER_W'(1) : timeout_q;
	assign send_slot = next_seq_q[srsw_pkg::SLOT_W-1:0];
	assign next_inc  = next_seq_q + 1'b1;
	assign send_ok   = (free_q != '0) && (peer_q != '0) && !pending_q[send_slot]
		&& (outs != srsw_pkg::SEQ_MASK);

	// Ack and nack distance from the window base.
	assign seq_dist = req_seq_q - base_seq_q;
	assign ack_ok   = seq_dist <= outs;
	assign nack_ok  = seq_dist < outs;
	assign ack_free = free_q + srsw_pkg::CNT_W'(seq_dist);

	// Slots released by a cumulative ack: ring offset from the base below the distance.
	always_comb begin
		logic [srsw_pkg::SLOT_W-1:0] off;
		for (int j = 0; j < srsw_pkg::WINDOW_SLOTS; j++) begin
			off = srsw_pkg::SLOT_W'(j) - base_seq_q[srsw_pkg::SLOT_W-1:0];
			ack_mask[j] = srsw_pkg::SEQ_BITS'(off) < seq_dist;
		end
	end

	// Tick scan: span, read address and evaluation of the slot whose timer was last read.
	assign span_now   = (outs > srsw_pkg::SEQ_BITS'(srsw_pkg::WINDOW_SLOTS))
		? srsw_pkg::CNT_W'(srsw_pkg::WINDOW_SLOTS) : srsw_pkg::CNT_W'(outs);
	assign scan_more  = cnt_q < span_q;
	assign scan_addr  = base_seq_q[srsw_pkg::SLOT_W-1:0] + cnt_q[srsw_pkg::SLOT_W-1:0];
	assign scan_pend  = pending_q[scan_slot_s1];
	assign tmr_dec    = (tmr_rd != '0) ? tmr_rd - 1'b1 : '0;
	assign expire     = scan_pend && (tmr_dec == '0);
	assign scan_stall = scan_vld_s1 && expire && !buf_stat.ready;

	assign req.ready = req_ready;
	assign cfg.ready = 1'b1;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srsw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, result selection and memory control.
	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		exec_fire  = 1'b0;
		scan_adv   = 1'b0;
		buf_ctrl   = '0;
		res        = '{action: srsw_pkg::ACT_NONE, slot: '0, seqnum: '0, adv: adv_now,
			empty: (outs == '0)};
		ram_we     = 1'b0;
		ram_waddr  = scan_slot_s1;
		ram_wdata  = expire ? reload : tmr_dec;
		ram_re     = 1'b0;
		unique case (state_q)
			srsw_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req.valid) begin
					state_d = srsw_pkg::ST_EXEC;
				end
			end
			srsw_pkg::ST_EXEC: begin
				unique case (req_kind_q)
					srsw_pkg::REQ_SEND: begin
						buf_ctrl = '{push: 1'b1, finish: 1'b1};
						if (send_ok) begin
							res.action = srsw_pkg::ACT_SEND;
							res.slot   = send_slot;
							res.seqnum = next_seq_q;
							res.empty  = (next_inc == base_seq_q);
						end
						ram_we    = buf_stat.ready && send_ok;
						ram_waddr = send_slot;
						ram_wdata = reload;
					end
					srsw_pkg::REQ_ACK: begin
						buf_ctrl = '{push: 1'b1, finish: 1'b1};
						if (ack_ok) begin
							res.action = srsw_pkg::ACT_ACK;
							res.adv    = srsw_pkg::adv_of(ack_free);
							res.empty  = (next_seq_q == req_seq_q);
						end else begin
							res.action = srsw_pkg::ACT_INVALID;
						end
					end
					srsw_pkg::REQ_NACK: begin
						buf_ctrl = '{push: 1'b1, finish: 1'b1};
						if (nack_ok) begin
							res.action = srsw_pkg::ACT_RESEND;
							res.slot   = req_seq_q[srsw_pkg::SLOT_W-1:0];
							res.seqnum = req_seq_q;
						end else begin
							res.action = srsw_pkg::ACT_INVALID;
						end
						ram_we    = buf_stat.ready && nack_ok;
						ram_waddr = req_seq_q[srsw_pkg::SLOT_W-1:0];
						ram_wdata = reload;
					end
					srsw_pkg::REQ_TICK: begin
						state_d = srsw_pkg::ST_SCAN;
					end
					default: begin
						state_d = srsw_pkg::ST_IDLE;
					end
				endcase
				if (req_kind_q != srsw_pkg::REQ_TICK && buf_stat.ready) begin
					exec_fire = 1'b1;
					state_d   = srsw_pkg::ST_IDLE;
				end
			end
			srsw_pkg::ST_SCAN: begin
				buf_ctrl.push = scan_vld_s1 && expire;
				res.action    = srsw_pkg::ACT_RESEND;
				res.slot      = scan_slot_s1;
				res.seqnum    = scan_seq_s1;
				if (!scan_stall) begin
					scan_adv = 1'b1;
					ram_we   = scan_vld_s1 && scan_pend;
					ram_re   = scan_more;
					if (!scan_more) begin
						state_d = srsw_pkg::ST_FIN;
					end
				end
			end
			srsw_pkg::ST_FIN: begin
				// Mark the held resend as last, or report a tick with nothing expired.
				buf_ctrl = '{push: !any_q, finish: 1'b1};
				if (buf_stat.ready) begin
					state_d = srsw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = srsw_pkg::ST_IDLE;
			end
		endcase
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (req.valid && req_ready) begin
			req_kind_q <= srsw_pkg::req_kind_t'(req.req_type);
			req_seq_q  <= req.seqnum;
			req_peer_q <= req.peer_window;
		end
	end

	// Timeout register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= srsw_pkg::TIMEOUT_RESET;
		end else if (cfg.valid) begin
			timeout_q <= cfg.data;
		end
	end

	// Window state updated by send, ack and nack.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_seq_q <= '0;
			next_seq_q <= '0;
			free_q     <= srsw_pkg::CNT_W'(srsw_pkg::WINDOW_SLOTS);
			peer_q     <= srsw_pkg::PEER_RESET;
			pending_q  <= '0;
		end else if (exec_fire) begin
			unique case (req_kind_q)
				srsw_pkg::REQ_SEND: begin
					if (send_ok) begin
						pending_q[send_slot] <= 1'b1;
						free_q               <= free_q - 1'b1;
						next_seq_q           <= next_inc;
					end
				end
				srsw_pkg::REQ_ACK: begin
					peer_q <= req_peer_q;
					if (ack_ok) begin
						pending_q  <= pending_q & ~ack_mask;
						free_q     <= ack_free;
						base_seq_q <= req_seq_q;
					end
				end
				srsw_pkg::REQ_NACK: begin
					peer_q <= req_peer_q;
					if (nack_ok) begin
						pending_q[req_seq_q[srsw_pkg::SLOT_W-1:0]] <= 1'b1;
					end
				end
				default: begin
					peer_q <= peer_q;
				end
			endcase
		end
	end

	// Tick scan counter and pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			span_q      <= '0;
			any_q       <= 1'b0;
			scan_vld_s1 <= 1'b0;
		end else if (state_q == srsw_pkg::ST_EXEC) begin
			cnt_q       <= '0;
			span_q      <= span_now;
			any_q       <= 1'b0;
			scan_vld_s1 <= 1'b0;
		end else if (scan_adv) begin
			scan_vld_s1 <= scan_more;
			if (scan_more) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (scan_vld_s1 && expire) begin
				any_q <= 1'b1;
			end
		end
	end

	// Slot and sequence number of the timer being read.
	always_ff @(posedge clk) begin
		if (scan_adv && scan_more) begin
			scan_slot_s1 <= scan_addr;
			scan_seq_s1  <= base_seq_q + srsw_pkg::SEQ_BITS'(cnt_q);
		end
	end

	// Slot timers. Each slot is read and written at most once per tick, and requests
	// run one at a time, so a read never meets a write to the same entry.
	srsw_ram #(
		.WIDTH(srsw_pkg::TIMER_W),
		.DEPTH(srsw_pkg::WINDOW_SLOTS)
	) u_timer_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(scan_addr),
		.rdata(tmr_rd)
	);

	srsw_result_buf u_result_buf (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (buf_ctrl),
		.res   (res),
		.stat  (buf_stat),
		.rsp   (rsp)
	);

	// Every outstanding sequence number holds exactly one slot.
	`SRSW_ASSERT_IMPLY(a_free_matches_outstanding, 1'b1,
		(srsw_pkg::SUM_W'(free_q) + srsw_pkg::SUM_W'(outs))
		== srsw_pkg::SUM_W'(srsw_pkg::WINDOW_SLOTS), "free slots out of step with window")
	// No result of a finished request is left behind in the hold stage.
	`SRSW_ASSERT_IMPLY(a_idle_hold_empty, state_q == srsw_pkg::ST_IDLE,
		!buf_stat.hold_busy, "result left in hold stage between requests")
	// The scan never runs past the outstanding span.
	`SRSW_ASSERT_IMPLY(a_scan_in_span, state_q == srsw_pkg::ST_SCAN, cnt_q <= span_q,
		"tick scan beyond outstanding span")
	// A stalled scan keeps the slot it is evaluating.
	`SRSW_ASSERT_NEXT(a_stall_holds_slot, scan_stall,
		scan_vld_s1 && $stable(scan_slot_s1) && $stable(scan_seq_s1),
		"tick scan lost its slot during a stall")

endmodule

### rtl/core/srsw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module srsw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; data holds while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/srsw_result_buf.sv
// Result staging for the send window: one hold stage and the output register.
// Depends on srsw_pkg and srsw_rsp_if. The hold stage lets the last mark be set late.
`timescale 1ns / 1ps

module srsw_result_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  srsw_pkg::buf_ctrl_t ctrl,
	input  srsw_pkg::result_t   res,
	output srsw_pkg::buf_stat_t stat,
	srsw_rsp_if.source          rsp
);

	logic              hold_vld_q;
	logic              out_vld_q;
	logic              out_last_q;
	srsw_pkg::result_t hold_q;
	srsw_pkg::result_t out_q;
	logic              can_move;
	logic              buf_ready;
	logic              take;
	logic              out_load;
	logic              hold_we;

	// The output register can accept a new result when empty or being drained.
	assign can_move  = !out_vld_q || rsp.ready;
	assign buf_ready = (hold_vld_q || ctrl.finish) ? can_move : 1'b1;
	assign take      = buf_ready && (ctrl.push || ctrl.finish);
	assign out_load  = take && (hold_vld_q || (ctrl.push && ctrl.finish));
	assign hold_we   = take && ctrl.push && (hold_vld_q || !ctrl.finish);

	assign stat.ready     = buf_ready;
	assign stat.hold_busy = hold_vld_q;

	// Occupancy of the hold stage and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (take) begin
				hold_vld_q <= hold_vld_q ? ctrl.push : (ctrl.push && !ctrl.finish);
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Result data. A held result becomes the last one when the request finishes.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q      <= hold_vld_q ? hold_q : res;
			out_last_q <= hold_vld_q ? (ctrl.finish && !ctrl.push) : 1'b1;
		end
		if (hold_we) begin
			hold_q <= res;
		end
	end

	assign rsp.valid             = out_vld_q;
	assign rsp.action            = out_q.action;
	assign rsp.slot              = out_q.slot;
	assign rsp.out_seqnum        = out_q.seqnum;
	assign rsp.advertised_window = out_q.adv;
	assign rsp.window_empty      = out_q.empty;
	assign rsp.last              = out_last_q;

endmodule

### verif/srsw_window_checker.sv
// Checker for the selective-repeat send window: watches the three channels,
// predicts the results of each request and compares them in order.
// Depends on srsw_pkg and the channel interfaces in srsw_if.
`timescale 1ns / 1ps

module srsw_window_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	srsw_req_if                           req,
	srsw_rsp_if                           rsp,
	srsw_cfg_if                           cfg,
	output int                            errors,
	output int                            queued,
	output logic [srsw_pkg::SEQ_BITS-1:0] seq_base,
	output logic [srsw_pkg::SEQ_BITS-1:0] seq_next
);
	import srsw_pkg::*;

	// One expected result, with its end-of-request mark.
	typedef struct packed {
		action_t             action;
		logic [SLOT_W-1:0]   slot;
		logic [SEQ_BITS-1:0] seqnum;
		logic [ADV_W-1:0]    adv;
		logic                empty;
		logic                last;
	} window_result_t;

	// Predicted window state.
	logic                in_flight [WINDOW_SLOTS];
	logic [TIMER_W-1:0]  countdown [WINDOW_SLOTS];
	logic [SEQ_BITS-1:0] win_base;
	logic [SEQ_BITS-1:0] win_next;
	logic [CNT_W-1:0]    free_cnt;
	logic [PEER_W-1:0]   peer_room;
	logic [TIMER_W-1:0]  timeout_reg;
	window_result_t      expected_results [$];

	// A timeout of zero behaves as one tick.
	function automatic logic [TIMER_W-1:0] reload_ticks();
		return (timeout_reg == '0) ? TIMER_W'(1) : timeout_reg;
	endfunction

	// Free slots minus one, clamped to the header field.
	function automatic logic [ADV_W-1:0] room_adv();
		if (free_cnt == '0) begin
			return '0;
		end else if (free_cnt > WINDOW_SLOTS) begin
			return ADV_MAX;
		end
		return ADV_W'(free_cnt - 1'b1);
	endfunction

	function automatic void push_result(action_t act, logic [SLOT_W-1:0] slot,
		logic [SEQ_BITS-1:0] seq);
		window_result_t r;
		r.action = act;
		r.slot = slot;
		r.seqnum = seq;
		r.adv = room_adv();
		r.empty = 1'b0;
		r.last = 1'b0;
		expected_results.push_back(r);
	endfunction

	// Update the window for one accepted request and queue what it should return.
	task automatic apply_request(req_kind_t kind, logic [SEQ_BITS-1:0] seq,
		logic [PEER_W-1:0] pw);
		int                  first;
		int                  span;
		int                  i;
		logic [SEQ_BITS-1:0] outs;
		logic [SEQ_BITS-1:0] seq_dist;
		logic [SEQ_BITS-1:0] sq;
		logic [SLOT_W-1:0]   s;
		logic                now_empty;
		window_result_t      r;
		first = expected_results.size();
		outs = win_next - win_base;
		seq_dist = seq - win_base;
		case (kind)
			REQ_SEND: begin
				s = win_next[SLOT_W-1:0];
				if (free_cnt != '0 && peer_room != '0 && !in_flight[s] && outs < SEQ_MASK) begin
					push_result(ACT_SEND, s, win_next);
					in_flight[s] = 1'b1;
					countdown[s] = reload_ticks();
					free_cnt = free_cnt - 1'b1;
					win_next = win_next + 1'b1;
				end else begin
					push_result(ACT_NONE, '0, '0);
				end
			end
			REQ_ACK: begin
				peer_room = pw;
				if (seq_dist <= outs) begin
					// Cumulative: release everything below the acked number.
					for (i = 0; i < int'(seq_dist); i++) begin
						sq = win_base + SEQ_BITS'(i);
						s = sq[SLOT_W-1:0];
						if (in_flight[s]) begin
							in_flight[s] = 1'b0;
							countdown[s] = '0;
							if (free_cnt < WINDOW_SLOTS) begin
								free_cnt = free_cnt + 1'b1;
							end
						end
					end
					win_base = seq;
					push_result(ACT_ACK, '0, '0);
				end else begin
					push_result(ACT_INVALID, '0, '0);
				end
			end
			REQ_NACK: begin
				peer_room = pw;
				if (seq_dist < outs) begin
					s = seq[SLOT_W-1:0];
					in_flight[s] = 1'b1;
					countdown[s] = reload_ticks();
					push_result(ACT_RESEND, s, seq);
				end else begin
					push_result(ACT_INVALID, '0, '0);
				end
			end
			REQ_TICK: begin
				// Scan from the base upward; expired timers resend and reload.
				span = (int'(outs) < WINDOW_SLOTS) ? int'(outs) : WINDOW_SLOTS;
				for (i = 0; i < span; i++) begin
					sq = win_base + SEQ_BITS'(i);
					s = sq[SLOT_W-1:0];
					if (!in_flight[s]) begin
						continue;
					end
					if (countdown[s] != '0) begin
						countdown[s] = countdown[s] - 1'b1;
					end
					if (countdown[s] == '0) begin
						countdown[s] = reload_ticks();
						push_result(ACT_RESEND, s, sq);
					end
				end
				if (expected_results.size() == first) begin
					push_result(ACT_NONE, '0, '0);
				end
			end
		endcase
		// The empty flag reflects the window after the request; mark the final result.
		now_empty = (win_next == win_base);
		for (i = first; i < expected_results.size(); i++) begin
			r = expected_results[i];
			r.empty = now_empty;
			r.last = (i == expected_results.size() - 1);
			expected_results[i] = r;
		end
	endtask

	function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s expected %0d actual %0d", name, want, got);
			errors++;
		end
	endfunction

	task automatic check_result();
		window_result_t want;
		if (expected_results.size() == 0) begin
			$error("unexpected result: action %0d seqnum %0d", rsp.action, rsp.out_seqnum);
			errors++;
			return;
		end
		want = expected_results.pop_front();
		compare_field("action", 16'(want.action), 16'(rsp.action));
		compare_field("slot", 16'(want.slot), 16'(rsp.slot));
		compare_field("out_seqnum", 16'(want.seqnum), 16'(rsp.out_seqnum));
		compare_field("advertised_window", 16'(want.adv), 16'(rsp.advertised_window));
		compare_field("window_empty", 16'(want.empty), 16'(rsp.window_empty));
		compare_field("last", 16'(want.last), 16'(rsp.last));
	endtask

	// Results are checked before the request of the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (in_flight[k]) begin
				in_flight[k] = 1'b0;
				countdown[k] = '0;
			end
			win_base = '0;
			win_next = '0;
			free_cnt = CNT_W'(WINDOW_SLOTS);
			peer_room = PEER_RESET;
			timeout_reg = TIMEOUT_RESET;
			expected_results.delete();
			errors = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				check_result();
			end
			if (cfg.valid && cfg.ready) begin
				timeout_reg = cfg.data;
			end
			if (req.valid && req.ready) begin
				apply_request(req_kind_t'(req.req_type), req.seqnum, req.peer_window);
			end
		end
		queued = expected_results.size();
		seq_base = win_base;
		seq_next = win_next;
	end

endmodule

### verif/tb_selective_repeat_send_window.sv
// Testbench top for the selective-repeat send window: clock, reset, request and
// timeout stimulus, receiver stalls and the verdict.
// Depends on srsw_pkg, srsw_if, the block itself and srsw_window_checker.
`timescale 1ns / 1ps

module tb_selective_repeat_send_window;
	import srsw_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic                clk;
	logic                arst_n;
	int                  errors;
	int                  queued;
	logic [SEQ_BITS-1:0] seq_base;
	logic [SEQ_BITS-1:0] seq_next;
	int                  burst_left;
	int                  idle_cycles = 0;

	srsw_req_if req_ch ();
	srsw_rsp_if rsp_ch ();
	srsw_cfg_if cfg_ch ();

	selective_repeat_send_window dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	srsw_window_checker window_check (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch),
		.errors(errors),
		.queued(queued),
		.seq_base(seq_base),
		.seq_next(seq_next)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: switches between steady, random and patterned stalling.
	initial begin
		int mode;
		int phase;
		mode = 0;
		phase = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (phase == 0) begin
				mode = $urandom_range(0, 3);
				phase = $urandom_range(20, 60);
			end
			phase--;
			case (mode)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= ($urandom_range(0, 2) != 0);
				2: rsp_ch.ready <= ((phase % 3) != 2);
				default: rsp_ch.ready <= ((phase % 7) == 0);
			endcase
		end
	end

	// Ends the run when no channel has moved for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("selective_repeat_send_window verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Waits for the next falling edge, inserting a gap between bursts.
	task automatic next_turn();
		if (burst_left == 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
		end else begin
			@(negedge clk);
		end
	endtask

	// Presents one request and holds it until it is taken.
	task automatic drive(req_kind_t kind, logic [SEQ_BITS-1:0] seq, logic [PEER_W-1:0] pw);
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.seqnum <= seq;
		req_ch.peer_window <= pw;
		do @(posedge clk); while (!req_ch.ready);
		burst_left--;
	endtask

	task automatic issue(req_kind_t kind, logic [SEQ_BITS-1:0] seq, logic [PEER_W-1:0] pw);
		next_turn();
		drive(kind, seq, pw);
	endtask

	// Drops valid and waits until every expected result has come out.
	task automatic settle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		burst_left = 0;
		while (queued != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_timeout(logic [TIMER_W-1:0] ticks);
		settle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= ticks;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Sends, ticks, and mostly well-formed acks and nacks aimed at the live window, plus noise.
	task automatic random_item();
		logic [SEQ_BITS-1:0] outs;
		logic [SEQ_BITS-1:0] seq;
		logic [PEER_W-1:0]   pw;
		int                  pick;
		next_turn();
		outs = seq_next - seq_base;
		pw = ($urandom_range(0, 9) == 0) ? '0 : PEER_W'($urandom_range(1, 31));
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			drive(REQ_SEND, SEQ_BITS'($urandom), PEER_W'($urandom));
		end else if (pick < 62) begin
			seq = ($urandom_range(0, 4) == 0) ? SEQ_BITS'($urandom)
				: seq_base + SEQ_BITS'($urandom_range(0, outs));
			drive(REQ_ACK, seq, pw);
		end else if (pick < 77) begin
			seq = (outs == '0 || $urandom_range(0, 4) == 0) ? SEQ_BITS'($urandom)
				: seq_base + SEQ_BITS'($urandom_range(0, outs - 1));
			drive(REQ_NACK, seq, pw);
		end else begin
			drive(REQ_TICK, SEQ_BITS'($urandom), PEER_W'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_SEND;
		req_ch.seqnum = '0;
		req_ch.peer_window = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		burst_left = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Empty window: idle tick, zero-distance ack, out-of-range ack.
		issue(REQ_TICK, '0, '0);
		issue(REQ_ACK, 8'd0, 5'd31);
		issue(REQ_ACK, 8'd5, 5'd0);
		// Peer window closed, so the send is refused; a stray nack reopens it.
		issue(REQ_SEND, '0, '0);
		issue(REQ_NACK, 8'd7, 5'd31);
		repeat (3) issue(REQ_SEND, '0, '0);
		// Nack inside the window, then just past its end.
		issue(REQ_NACK, 8'd1, 5'd17);
		issue(REQ_NACK, 8'd3, 5'd17);
		issue(REQ_ACK, 8'd2, 5'd31);
		issue(REQ_ACK, 8'd255, 5'd31);
		issue(REQ_TICK, 8'd255, 5'd31);
		issue(REQ_ACK, 8'd3, 5'd0);
		issue(REQ_NACK, 8'd3, 5'd31);

		// Shortest timeout: every tick expires the pending timers.
		write_timeout(16'd1);
		repeat (2) issue(REQ_SEND, '0, '0);
		issue(REQ_TICK, '0, '0);
		issue(REQ_ACK, 8'd4, 5'd31);
		issue(REQ_TICK, '0, '0);

		// A zero timeout behaves as one tick.
		write_timeout(16'd0);
		issue(REQ_SEND, '0, '0);
		issue(REQ_TICK, '0, '0);
		issue(REQ_ACK, 8'd6, 5'd31);

		// Fill the window to the refusal point, expire all of it, then ack it all.
		repeat (33) issue(REQ_SEND, SEQ_BITS'($urandom), PEER_W'($urandom));
		issue(REQ_TICK, '0, '0);
		next_turn();
		drive(REQ_ACK, seq_next, PEER_W'($urandom_range(1, 31)));

		// Random phases under several timeouts, the longest among them.
		write_timeout(16'd65535);
		repeat (10) random_item();
		write_timeout(16'd3);
		repeat (10) random_item();
		write_timeout(16'd2);
		repeat (10) random_item();
		write_timeout(TIMER_W'($urandom_range(1, 8)));
		repeat (10) random_item();
		write_timeout(16'd1);
		repeat (10) random_item();

		settle();
		repeat (8) @(negedge clk);
		if (errors == 0 && queued == 0) begin
			$display("selective_repeat_send_window verification clean");
		end else begin
			$display("selective_repeat_send_window verification failed");
		end
		$finish;
	end

endmodule
